[hw/rtl/ray_box_slab_test_top_macros.svh]
// ----------------------------------------------------------------------------
// ray_box_slab_test_top_macros.svh
// Assertion macros for the ray/box slab test. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_TOP_MACROS_SVH
`define RAY_BOX_SLAB_TEST_TOP_MACROS_SVH

`ifndef SYNTH
// plain clocked property, reset masked
`define RBST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define RBST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RBST_ASSERT(lbl, prop, msg)
`define RBST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// Types and constants shared by the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

	typedef logic signed [31:0] q16_t;   // signed Q16.16
	typedef logic signed [32:0] diff_t;  // corner minus origin, Q17.16
	typedef logic signed [63:0] tval_t;  // ray parameter, Q32.32
	typedef logic [30:0]        len_t;   // unsigned Q15.16

	localparam int unsigned REG_IDX_W = 3;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_MIN_X = 3'd0;
	localparam reg_idx_t REG_MIN_Y = 3'd1;
	localparam reg_idx_t REG_MIN_Z = 3'd2;
	localparam reg_idx_t REG_MAX_X = 3'd3;
	localparam reg_idx_t REG_MAX_Y = 3'd4;
	localparam reg_idx_t REG_MAX_Z = 3'd5;
	localparam reg_idx_t NUM_REGS  = 3'd6;

	localparam q16_t BOX_MIN_RST = -32'sd65536;
	localparam q16_t BOX_MAX_RST = 32'sd65536;

	typedef struct packed {
		q16_t [2:0] lo;
		q16_t [2:0] hi;
	} box_t;

	typedef struct packed {
		q16_t [2:0] org;
		q16_t [2:0] inv;
		logic [2:0] neg;
		len_t       len;
	} ray_t;

	// after corner select and subtract
	typedef struct packed {
		diff_t [2:0] dn;
		diff_t [2:0] df;
		q16_t  [2:0] inv;
		len_t        len;
	} s1_t;

	// near/far t per axis
	typedef struct packed {
		tval_t [2:0] tn;
		tval_t [2:0] tf;
		len_t        len;
	} s2_t;

	// x/y interval plus z slab still to apply
	typedef struct packed {
		tval_t t0;
		tval_t t1;
		tval_t tzn;
		tval_t tzf;
		logic  ok;
		len_t  len;
	} s3_t;

	// final interval
	typedef struct packed {
		tval_t t0;
		tval_t t1;
		logic  ok;
		len_t  len;
	} s4_t;

endpackage

[hw/rtl/rbst_diff.sv]
// ----------------------------------------------------------------------------
// rbst_diff
// Stage 1: picks near/far corner per axis and subtracts the ray origin.
// ----------------------------------------------------------------------------
module rbst_diff (
	input  logic          clk,
	input  logic          arst_n,
	input  rbst_pkg::box_t box,
	input  logic          in_valid,
	output logic          in_ready,
	input  rbst_pkg::ray_t ray,
	output logic          out_valid,
	input  logic          out_ready,
	output rbst_pkg::s1_t out_data
);

	logic          v_s1;
	rbst_pkg::s1_t d_s1;
	rbst_pkg::s1_t d_nxt;

	always_comb begin
		d_nxt = '0;
		for (int i = 0; i < 3; i++) begin
			rbst_pkg::q16_t near_c;
			rbst_pkg::q16_t far_c;
			near_c = ray.neg[i] ? box.hi[i] : box.lo[i];
			far_c  = ray.neg[i] ? box.lo[i] : box.hi[i];
			d_nxt.dn[i] = $signed({near_c[31], near_c}) - $signed({ray.org[i][31], ray.org[i]});
			d_nxt.df[i] = $signed({far_c[31], far_c}) - $signed({ray.org[i][31], ray.org[i]});
		end
		d_nxt.inv = ray.inv;
		d_nxt.len = ray.len;
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= d_nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

[hw/rtl/rbst_mul.sv]
// ----------------------------------------------------------------------------
// rbst_mul
// Stage 2: six exact 33x32 signed products, near/far t per axis in Q32.32.
// ----------------------------------------------------------------------------
module rbst_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rbst_pkg::s1_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rbst_pkg::s2_t out_data
);

	logic          v_s2;
	rbst_pkg::s2_t d_s2;
	rbst_pkg::s2_t d_nxt;

	always_comb begin
		d_nxt = '0;
		for (int i = 0; i < 3; i++) begin
			logic signed [64:0] pn;
			logic signed [64:0] pf;
			pn = 65'($signed(in_data.dn[i])) * 65'($signed(in_data.inv[i]));
			pf = 65'($signed(in_data.df[i])) * 65'($signed(in_data.inv[i]));
			// |product| < 2^63, top bit is only sign extension
			d_nxt.tn[i] = pn[63:0];
			d_nxt.tf[i] = pf[63:0];
		end
		d_nxt.len = in_data.len;
	end

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s2 <= d_nxt;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule

[hw/rtl/rbst_narrow.sv]
// ----------------------------------------------------------------------------
// rbst_narrow
// Stages 3 and 4: x/y slab overlap and narrowing, then the z slab.
// ----------------------------------------------------------------------------
module rbst_narrow (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rbst_pkg::s2_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rbst_pkg::s4_t out_data
);

	logic          v_s3;
	logic          v_s4;
	logic          rdy_s3;
	logic          rdy_s4;
	rbst_pkg::s3_t d_s3;
	rbst_pkg::s4_t d_s4;
	rbst_pkg::s3_t s3_nxt;
	rbst_pkg::s4_t s4_nxt;

	// x slab against y slab
	always_comb begin
		rbst_pkg::tval_t xn, xf, yn, yf;
		xn = in_data.tn[0];
		xf = in_data.tf[0];
		yn = in_data.tn[1];
		yf = in_data.tf[1];
		s3_nxt     = '0;
		s3_nxt.ok  = !(($signed(xn) > $signed(yf)) || ($signed(yn) > $signed(xf)));
		s3_nxt.t0  = ($signed(yn) > $signed(xn)) ? yn : xn;
		s3_nxt.t1  = ($signed(yf) < $signed(xf)) ? yf : xf;
		s3_nxt.tzn = in_data.tn[2];
		s3_nxt.tzf = in_data.tf[2];
		s3_nxt.len = in_data.len;
	end

	// z slab against the narrowed interval
	always_comb begin
		s4_nxt     = '0;
		s4_nxt.ok  = d_s3.ok && !(($signed(d_s3.t0) > $signed(d_s3.tzf)) ||
			($signed(d_s3.tzn) > $signed(d_s3.t1)));
		s4_nxt.t0  = ($signed(d_s3.tzn) > $signed(d_s3.t0)) ? d_s3.tzn : d_s3.t0;
		s4_nxt.t1  = ($signed(d_s3.tzf) < $signed(d_s3.t1)) ? d_s3.tzf : d_s3.t1;
		s4_nxt.len = d_s3.len;
	end

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= in_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			d_s3 <= s3_nxt;
		end
		if (rdy_s4 && v_s3) begin
			d_s4 <= s4_nxt;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = d_s4;

endmodule

[hw/rtl/ray_box_slab_test_top.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray versus axis-aligned box test (slab method), five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one ray per beat: origin, inverse
//   direction, direction sign bits and max_length. Output channel
//   (out_valid/out_ready) returns one hit bit per ray, in order.
//   Box corners sit in six registers written through cfg_we/cfg_index/
//   cfg_data (min x,y,z then max x,y,z); index 6 and 7 are ignored. Write
//   only while no ray is in flight.
//   Stages, in order: subtract, multiply (six 33x32 products), x/y slab, z
//   slab, final length check. Throughput is one ray per cycle while the
//   receiver keeps out_ready high; each stage has its own valid bit.
//   A stalled receiver holds the last stage, and ready backs up stage by
//   stage, so bubbles are squeezed out before in_ready drops.
//   Reset clears all valid bits and loads the box as [-1,1] on every axis.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_top_macros.svh"

module ray_box_slab_test_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// ray input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] origin_x,
	input  logic [31:0] origin_y,
	input  logic [31:0] origin_z,
	input  logic [31:0] inv_dir_x,
	input  logic [31:0] inv_dir_y,
	input  logic [31:0] inv_dir_z,
	input  logic        neg_x,
	input  logic        neg_y,
	input  logic        neg_z,
	input  logic [30:0] max_length,
	// result
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit
);

	rbst_pkg::q16_t [2:0] box_min_q;
	rbst_pkg::q16_t [2:0] box_max_q;
	rbst_pkg::box_t       box;
	rbst_pkg::ray_t       ray;

	logic          s1_valid, s1_ready;
	logic          s2_valid, s2_ready;
	logic          s4_valid, s4_ready;
	rbst_pkg::s1_t s1_data;
	rbst_pkg::s2_t s2_data;
	rbst_pkg::s4_t s4_data;

	logic          v_s5;
	logic          hit_s5;
	logic          hit_nxt;
	rbst_pkg::tval_t len_q32;

	// box corner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q <= {3{rbst_pkg::BOX_MIN_RST}};
			box_max_q <= {3{rbst_pkg::BOX_MAX_RST}};
		end else if (cfg_we) begin
			case (cfg_index)
				rbst_pkg::REG_MIN_X: box_min_q[0] <= cfg_data;
				rbst_pkg::REG_MIN_Y: box_min_q[1] <= cfg_data;
				rbst_pkg::REG_MIN_Z: box_min_q[2] <= cfg_data;
				rbst_pkg::REG_MAX_X: box_max_q[0] <= cfg_data;
				rbst_pkg::REG_MAX_Y: box_max_q[1] <= cfg_data;
				rbst_pkg::REG_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign box.lo = box_min_q;
	assign box.hi = box_max_q;

	assign ray.org = {origin_z, origin_y, origin_x};
	assign ray.inv = {inv_dir_z, inv_dir_y, inv_dir_x};
	assign ray.neg = {neg_z, neg_y, neg_x};
	assign ray.len = max_length;

	rbst_diff u_diff (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (box),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ray       (ray),
		.out_valid (s1_valid),
		.out_ready (s1_ready),
		.out_data  (s1_data)
	);

	rbst_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_ready  (s1_ready),
		.in_data   (s1_data),
		.out_valid (s2_valid),
		.out_ready (s2_ready),
		.out_data  (s2_data)
	);

	rbst_narrow u_narrow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s2_valid),
		.in_ready  (s2_ready),
		.in_data   (s2_data),
		.out_valid (s4_valid),
		.out_ready (s4_ready),
		.out_data  (s4_data)
	);

	// stage 5: entry below max_length, exit above zero
	assign len_q32 = $signed({17'd0, s4_data.len, 16'd0});
	assign hit_nxt = s4_data.ok && ($signed(s4_data.t0) < $signed(len_q32)) &&
		($signed(s4_data.t1) > 64'sd0);

	assign s4_ready = !v_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (s4_ready) begin
			v_s5 <= s4_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_ready && s4_valid) begin
			hit_s5 <= hit_nxt;
		end
	end

	assign out_valid = v_s5;
	assign hit       = hit_s5;

	`RBST_ASSERT_NEXT(a_s4_to_out, s4_valid && s4_ready, out_valid, "s4 beat lost")
	`RBST_ASSERT_NEXT(a_reject_no_hit, s4_valid && s4_ready && !s4_data.ok, !hit, "reject gave hit")
	`RBST_ASSERT(a_stall_has_item, in_ready || s1_valid, "input stalled with empty stage 1")
	`RBST_ASSERT_NEXT(a_bad_index_noop, cfg_we && (cfg_index >= rbst_pkg::NUM_REGS),
		$stable(box_min_q) && $stable(box_max_q), "write to unknown index changed box")

endmodule
